// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the console cursor RTL.
// Clocked, reset-qualified property checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
// Shared types, codes and constants of the text console cursor engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int RES_Q_DEPTH  = 4;

    localparam logic [7:0]  FORE_RST   = 8'd5;
    localparam logic [7:0]  BACK_RST   = 8'd0;
    localparam logic [15:0] PERIOD_RST = 16'd500;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_BACKSP  = 8'd8;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    typedef enum logic [2:0] {
        ACT_PUT    = 3'd0,
        ACT_SETPOS = 3'd1,
        ACT_TICK   = 3'd2,
        ACT_SETVIS = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_REDRAW = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        CMD_GLYPH     = 3'd0,
        CMD_SCROLL    = 3'd1,
        CMD_UNDERLINE = 3'd2,
        CMD_ERASE     = 3'd3,
        CMD_CLEAR     = 3'd4
    } t_command;

    typedef enum logic [1:0] {
        REG_FORE   = 2'd0,
        REG_BACK   = 2'd1,
        REG_PERIOD = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_action    action;
        logic [7:0] char_code;
        logic [7:0] col_value;
        logic [7:0] row_value;
        logic       visible_flag;
    } t_item;

    typedef struct packed {
        t_command   command;
        logic [7:0] cell_col;
        logic [6:0] cell_row;
        logic [7:0] glyph_code;
        logic [7:0] fore_out;
        logic [7:0] back_out;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic [7:0]  col;
        logic [6:0]  row;
        logic        shown;
        logic        phase;
        logic [15:0] ticks;
    } t_cursor;

    typedef struct packed {
        logic [7:0]  fore;
        logic [7:0]  back;
        logic [15:0] period;
    } t_cfg;

    function automatic t_result make_res(t_command cmd, logic [7:0] col, logic [6:0] row,
                                         logic [7:0] glyph, logic [7:0] fore,
                                         logic [7:0] back);
        t_result r;
        r.command     = cmd;
        r.cell_col    = col;
        r.cell_row    = row;
        r.glyph_code  = glyph;
        r.fore_out    = fore;
        r.back_out    = back;
        r.last_of_run = 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/tcce_step.sv =====
// Single-pass cursor update: next cursor state and up to two draw commands.
// Pure combinational logic; depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_step
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  t_item      i_item,
    input  t_cursor    i_cur,
    input  t_cfg       i_cfg,
    output t_cursor    o_cur,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_res_cnt
);

    localparam logic [8:0] COLS9    = 9'(COLUMNS);
    localparam logic [7:0] ROWS8    = 8'(ROWS);
    localparam logic [6:0] ROW_LAST = 7'(ROWS - 1);

    logic [8:0]  col_p1;
    logic [8:0]  tab_col;
    logic [7:0]  row_p1;
    logic        wrap_row;
    logic [6:0]  nl_row;
    logic [15:0] tick_cnt;
    t_result     scroll_res;

    always_comb begin
        col_p1     = {1'b0, i_cur.col} + 9'd1;
        tab_col    = ({1'b0, i_cur.col} + 9'd4) & ~9'd3;
        row_p1     = {1'b0, i_cur.row} + 8'd1;
        wrap_row   = (row_p1 >= ROWS8);
        nl_row     = wrap_row ? ROW_LAST : row_p1[6:0];
        tick_cnt   = (i_cur.ticks == 16'hFFFF) ? i_cur.ticks : i_cur.ticks + 16'd1;
        scroll_res = make_res(CMD_SCROLL, 8'd0, ROW_LAST, 8'd0, 8'd0, i_cfg.back);
    end

    always_comb begin
        o_cur     = i_cur;
        o_res0    = '0;
        o_res1    = '0;
        o_res_cnt = 2'd0;
        unique case (i_item.action)
            ACT_PUT: begin
                priority if (i_item.char_code == CH_NEWLINE) begin
                    o_cur.col = 8'd0;
                    o_cur.row = nl_row;
                    if (wrap_row) begin
                        o_res0    = scroll_res;
                        o_res_cnt = 2'd1;
                    end
                end else if (i_item.char_code == CH_RETURN) begin
                    o_cur.col = 8'd0;
                end else if (i_item.char_code == CH_TAB) begin
                    if (tab_col >= COLS9) begin
                        o_cur.col = 8'd0;
                        o_cur.row = nl_row;
                        if (wrap_row) begin
                            o_res0    = scroll_res;
                            o_res_cnt = 2'd1;
                        end
                    end else begin
                        o_cur.col = tab_col[7:0];
                    end
                end else if (i_item.char_code == CH_BACKSP) begin
                    if (i_cur.col != 8'd0) begin
                        o_cur.col = i_cur.col - 8'd1;
                        o_res0    = make_res(CMD_GLYPH, i_cur.col - 8'd1, i_cur.row,
                                             CH_SPACE, i_cfg.fore, i_cfg.back);
                        o_res_cnt = 2'd1;
                    end
                end else begin
                    o_res0    = make_res(CMD_GLYPH, i_cur.col, i_cur.row,
                                         i_item.char_code, i_cfg.fore, i_cfg.back);
                    o_res_cnt = 2'd1;
                    if (col_p1 >= COLS9) begin
                        o_cur.col = 8'd0;
                        o_cur.row = nl_row;
                        if (wrap_row) begin
                            // glyph then scroll: glyph is no longer the last word
                            o_res0.last_of_run = 1'b0;
                            o_res1             = scroll_res;
                            o_res_cnt          = 2'd2;
                        end
                    end else begin
                        o_cur.col = col_p1[7:0];
                    end
                end
            end
            ACT_SETPOS: begin
                if ({1'b0, i_item.col_value} < COLS9) begin
                    o_cur.col = i_item.col_value;
                end
                if (i_item.row_value < ROWS8) begin
                    o_cur.row = i_item.row_value[6:0];
                end
            end
            ACT_TICK: begin
                o_cur.ticks = tick_cnt;
                if (i_cur.shown && (tick_cnt >= i_cfg.period)) begin
                    o_cur.phase = ~i_cur.phase;
                    o_cur.ticks = 16'd0;
                    o_res_cnt   = 2'd1;
                    if (!i_cur.phase) begin
                        o_res0 = make_res(CMD_UNDERLINE, i_cur.col, i_cur.row, 8'd0,
                                          i_cfg.fore, 8'd0);
                    end else begin
                        o_res0 = make_res(CMD_ERASE, i_cur.col, i_cur.row, 8'd0,
                                          8'd0, i_cfg.back);
                    end
                end
            end
            ACT_SETVIS: begin
                o_cur.shown = i_item.visible_flag;
                if (!i_item.visible_flag) begin
                    o_res0    = make_res(CMD_ERASE, i_cur.col, i_cur.row, 8'd0,
                                         8'd0, i_cfg.back);
                    o_res_cnt = 2'd1;
                end
            end
            ACT_CLEAR: begin
                o_cur.col = 8'd0;
                o_cur.row = 7'd0;
                o_res0    = make_res(CMD_CLEAR, 8'd0, 7'd0, 8'd0, 8'd0, i_cfg.back);
                o_res_cnt = 2'd1;
            end
            ACT_REDRAW: begin
                if (i_cur.shown && i_cur.phase) begin
                    o_res0    = make_res(CMD_UNDERLINE, i_cur.col, i_cur.row, 8'd0,
                                         i_cfg.fore, 8'd0);
                    o_res_cnt = 2'd1;
                end
            end
            default: begin
                // unused action codes: no change, no word
            end
        endcase
    end

endmodule

// ===== rtl/tcce_res_fifo.sv =====
// Small result queue: takes zero, one or two words per cycle, gives one while i_ready is high.
// Register array with head/tail pointers; depends on tcce_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcce_res_fifo
    import tcce_pkg::*;
#(
    parameter int DEPTH = RES_Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_data0,
    input  t_result    i_data1,
    output logic       o_room2,
    output logic       o_valid,
    output t_result    o_data,
    input  logic       i_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic [PW-1:0]  wr_ptr1;
    logic           pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign wr_ptr1 = PW'(r_wr_ptr + PW'(1));

    always_comb begin
        n_wr_ptr = PW'(r_wr_ptr + PW'(i_push_cnt));
        n_rd_ptr = pop ? PW'(r_rd_ptr + PW'(1)) : r_rd_ptr;
        n_count  = CW'(r_count + CW'(i_push_cnt) - CW'(pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    assign o_data = r_mem[r_rd_ptr];

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH), "result queue overfull")
    `ASSERT_NEVER(a_push_room, i_clk, i_rst_n, (i_push_cnt != 2'd0) && !o_room2, "push without room")
    `ASSERT_CLK(a_drain_last, i_clk, i_rst_n, (r_count == CW'(1)) && pop && (i_push_cnt == 2'd0) |=> !o_valid, "queue not empty after last pop")

endmodule

// ===== rtl/text_console_cursor_engine_unit.sv =====
// Channel      Dir  Payload (low bit first)                          Handshake
// s_axis       in   tuser: action; tdata: char, col, row, visible     tvalid/tready
// m_axis       out  tuser: command; tdata: col, row, glyph, fore, back; tlast  tvalid/tready
// apb          in   fore 0x0, back 0x4, blink period 0x8              psel/penable, pready=1
//
// An input word waits in the input register until the queue has room, then the step
// logic updates the cursor and pushes its draw words into a four-entry result queue.
// A word goes through the input register and then the result queue; one word is accepted
// per cycle while the queue holds at most two words, so the output port bounds throughput.
// Reset is synchronous and active low; it restores the cursor and registers.
// Output stalls hold the queue; the input stalls only when the queue lacks room.
// Top level of the text console cursor engine; uses tcce_pkg, tcce_step,
// tcce_res_fifo and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // char_code, col_value, row_value, visible_flag
    input  logic [2:0]  i_s_axis_tuser,  // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // cell_col, cell_row, glyph_code, fore_out, back_out
    output logic [2:0]  o_m_axis_tuser,  // command
    output logic        o_m_axis_tlast,  // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cursor    r_cur;
    t_cfg       r_cfg;
    logic       r_in_valid;
    t_item      r_item;
    t_cursor    step_cur;
    t_result    step_res0, step_res1;
    logic [1:0] step_cnt;
    logic       room2;
    logic       do_step;
    logic       in_take;
    logic       cfg_wr;
    t_reg_idx   reg_idx;
    t_result    out_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    assign do_step         = r_in_valid && room2;
    assign o_s_axis_tready = !r_in_valid || room2;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fore   <= FORE_RST;
            r_cfg.back   <= BACK_RST;
            r_cfg.period <= PERIOD_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FORE:   r_cfg.fore   <= pwdata[7:0];
                REG_BACK:   r_cfg.back   <= pwdata[7:0];
                REG_PERIOD: r_cfg.period <= pwdata[15:0];
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FORE:   prdata = {24'd0, r_cfg.fore};
            REG_BACK:   prdata = {24'd0, r_cfg.back};
            REG_PERIOD: prdata = {16'd0, r_cfg.period};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (do_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.action       <= t_action'(i_s_axis_tuser);
            r_item.char_code    <= i_s_axis_tdata[7:0];
            r_item.col_value    <= i_s_axis_tdata[15:8];
            r_item.row_value    <= i_s_axis_tdata[23:16];
            r_item.visible_flag <= i_s_axis_tdata[24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur.col   <= 8'd0;
            r_cur.row   <= 7'd0;
            r_cur.shown <= 1'b1;
            r_cur.phase <= 1'b1;
            r_cur.ticks <= 16'd0;
        end else if (do_step) begin
            r_cur <= step_cur;
        end
    end

    tcce_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_step (
        .i_item    (r_item),
        .i_cur     (r_cur),
        .i_cfg     (r_cfg),
        .o_cur     (step_cur),
        .o_res0    (step_res0),
        .o_res1    (step_res1),
        .o_res_cnt (step_cnt)
    );

    tcce_res_fifo #(
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (do_step ? step_cnt : 2'd0),
        .i_data0    (step_res0),
        .i_data1    (step_res1),
        .o_room2    (room2),
        .o_valid    (o_m_axis_tvalid),
        .o_data     (out_res),
        .i_ready    (i_m_axis_tready)
    );

    assign o_m_axis_tuser = out_res.command;
    assign o_m_axis_tlast = out_res.last_of_run;
    assign o_m_axis_tdata = {1'b0, out_res.back_out, out_res.fore_out, out_res.glyph_code,
                             out_res.cell_row, out_res.cell_col};

    `ASSERT_NEVER(a_col_range, i_clk, i_rst_n, {1'b0, r_cur.col} >= 9'(COLUMNS), "cursor column out of range")
    `ASSERT_NEVER(a_row_range, i_clk, i_rst_n, {1'b0, r_cur.row} >= 8'(ROWS), "cursor row out of range")
    `ASSERT_CLK(a_hold_item, i_clk, i_rst_n, r_in_valid && !room2 |=> r_in_valid && $stable(r_item), "pending word lost")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for text_console_cursor_engine_unit: stream stimulus, APB setup,
// an in-bench cursor predictor and a scoreboard on the draw-command stream.
// Depends on tcce_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module testbench;
    import tcce_pkg::*;

    localparam int NCOLS = COLUMNS_DEF;
    localparam int NROWS = ROWS_DEF;
    localparam logic [2:0] ACT_RESERVED_A = 3'd6;
    localparam logic [2:0] ACT_RESERVED_B = 3'd7;
    localparam int MAX_REPORTS = 30;

    logic        i_clk    = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;  // cell_col, cell_row, glyph_code, fore_out, back_out
    logic [2:0]  o_m_axis_tuser;  // command
    logic        o_m_axis_tlast;  // last_of_run
    logic [31:0] prdata;
    logic        pready;

    text_console_cursor_engine_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted cursor state and register copies
    logic [7:0]  cur_col;
    logic [6:0]  cur_row;
    logic        cur_shown;
    logic        blink_on;
    logic [15:0] tick_count;
    logic [7:0]  fore_reg;
    logic [7:0]  back_reg;
    logic [15:0] period_reg;

    t_result draw_words_due[$];
    bit      idle_on = 1'b1;
    int      mismatch_count = 0;
    int      words_checked = 0;
    int      items_sent = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch(name, got, want);
    endtask

    function automatic void queue_draw(t_command cmd, logic [7:0] col, logic [6:0] row,
                                       logic [7:0] glyph, logic [7:0] fg, logic [7:0] bg);
        t_result w;
        w.command     = cmd;
        w.cell_col    = col;
        w.cell_row    = row;
        w.glyph_code  = glyph;
        w.fore_out    = fg;
        w.back_out    = bg;
        w.last_of_run = 1'b0;
        draw_words_due.push_back(w);
    endfunction

    function automatic void line_feed();
        cur_col = '0;
        if (int'(cur_row) + 1 >= NROWS) begin
            cur_row = 7'(NROWS - 1);
            queue_draw(CMD_SCROLL, 8'd0, 7'(NROWS - 1), 8'd0, 8'd0, back_reg);
        end else begin
            cur_row = cur_row + 7'd1;
        end
    endfunction

    function automatic void advance_cursor(t_item it);
        int first_new;
        int next_tab;
        t_result tail;
        first_new = draw_words_due.size();
        case (it.action)
            ACT_PUT: begin
                if (it.char_code == CH_NEWLINE) begin
                    line_feed();
                end else if (it.char_code == CH_RETURN) begin
                    cur_col = '0;
                end else if (it.char_code == CH_TAB) begin
                    next_tab = (int'(cur_col) + 4) & ~3;
                    if (next_tab >= NCOLS)
                        line_feed();
                    else
                        cur_col = 8'(next_tab);
                end else if (it.char_code == CH_BACKSP) begin
                    if (cur_col != 0) begin
                        cur_col = cur_col - 8'd1;
                        queue_draw(CMD_GLYPH, cur_col, cur_row, CH_SPACE, fore_reg, back_reg);
                    end
                end else begin
                    queue_draw(CMD_GLYPH, cur_col, cur_row, it.char_code, fore_reg, back_reg);
                    if (int'(cur_col) + 1 >= NCOLS)
                        line_feed();
                    else
                        cur_col = cur_col + 8'd1;
                end
            end
            ACT_SETPOS: begin
                if (int'(it.col_value) < NCOLS)
                    cur_col = it.col_value;
                if (int'(it.row_value) < NROWS)
                    cur_row = it.row_value[6:0];
            end
            ACT_TICK: begin
                if (tick_count != 16'hFFFF)
                    tick_count = tick_count + 16'd1;
                if (cur_shown && tick_count >= period_reg) begin
                    blink_on   = !blink_on;
                    tick_count = '0;
                    if (blink_on)
                        queue_draw(CMD_UNDERLINE, cur_col, cur_row, 8'd0, fore_reg, 8'd0);
                    else
                        queue_draw(CMD_ERASE, cur_col, cur_row, 8'd0, 8'd0, back_reg);
                end
            end
            ACT_SETVIS: begin
                cur_shown = it.visible_flag;
                if (!it.visible_flag)
                    queue_draw(CMD_ERASE, cur_col, cur_row, 8'd0, 8'd0, back_reg);
            end
            ACT_CLEAR: begin
                queue_draw(CMD_CLEAR, 8'd0, 7'd0, 8'd0, 8'd0, back_reg);
                cur_col = '0;
                cur_row = '0;
            end
            ACT_REDRAW: begin
                if (cur_shown && blink_on)
                    queue_draw(CMD_UNDERLINE, cur_col, cur_row, 8'd0, fore_reg, 8'd0);
            end
            default: ;
        endcase
        // flag the final word of this input
        if (draw_words_due.size() > first_new) begin
            tail = draw_words_due.pop_back();
            tail.last_of_run = 1'b1;
            draw_words_due.push_back(tail);
        end
    endfunction

    // Hold tvalid across back-to-back words; drop it only for a gap.
    task automatic send_word(input t_item it);
        if (idle_on && $urandom_range(5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.visible_flag, it.row_value, it.col_value, it.char_code};
        s_tuser  <= it.action;
        do @(posedge i_clk); while (!o_s_axis_tready);
        advance_cursor(it);
        items_sent++;
    endtask

    task automatic send_op(input logic [2:0] act, input logic [7:0] ch, input logic [7:0] col,
                           input logic [7:0] row, input logic vis);
        t_item it;
        it.action       = t_action'(act);
        it.char_code    = ch;
        it.col_value    = col;
        it.row_value    = row;
        it.visible_flag = vis;
        send_word(it);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FORE:   fore_reg = value[7:0];
            REG_BACK:   back_reg = value[7:0];
            REG_PERIOD: period_reg = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drain outstanding words, then cover words that cause no output still in flight.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (draw_words_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_item random_item();
        t_item it;
        int pick;
        int sub;
        pick = $urandom_range(99);
        sub  = $urandom_range(9);
        it.char_code    = 8'($urandom);
        it.col_value    = 8'($urandom);
        it.row_value    = 8'($urandom);
        it.visible_flag = 1'($urandom);
        it.action       = ACT_PUT;
        if (pick < 45) begin
            case (sub)
                0: it.char_code = CH_NEWLINE;
                1: it.char_code = CH_RETURN;
                2: it.char_code = CH_TAB;
                3: it.char_code = CH_BACKSP;
                default: ;
            endcase
        end else if (pick < 60) begin
            it.action = ACT_SETPOS;
            if (sub > 2) begin
                it.col_value = 8'($urandom_range(NCOLS - 1));
                it.row_value = 8'($urandom_range(NROWS - 1));
            end
        end else if (pick < 75) begin
            it.action = ACT_TICK;
        end else if (pick < 83) begin
            it.action = ACT_SETVIS;
            if (sub > 3)
                it.visible_flag = 1'b1;
        end else if (pick < 88) begin
            it.action = ACT_CLEAR;
        end else if (pick < 96) begin
            it.action = ACT_REDRAW;
        end else begin
            it.action = t_action'(sub[0] ? ACT_RESERVED_A : ACT_RESERVED_B);
        end
        return it;
    endfunction

    task automatic test_directed_cases();
        send_op(ACT_PUT, 8'h41, 8'h00, 8'h00, 1'b0);
        send_op(ACT_PUT, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_op(ACT_PUT, 8'h00, 8'h00, 8'h00, 1'b0);
        // wrap at the bottom-right cell: glyph then scroll
        send_op(ACT_SETPOS, 8'h00, 8'(NCOLS - 1), 8'(NROWS - 1), 1'b0);
        send_op(ACT_PUT, 8'h5A, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETPOS, 8'h00, 8'(NCOLS - 2), 8'd3, 1'b0);
        send_op(ACT_PUT, CH_TAB, 8'h00, 8'h00, 1'b0);
        send_op(ACT_PUT, CH_TAB, 8'h00, 8'h00, 1'b0);
        send_op(ACT_PUT, CH_BACKSP, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETPOS, 8'h00, 8'd0, 8'd7, 1'b0);
        send_op(ACT_PUT, CH_BACKSP, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETPOS, 8'h00, 8'd9, 8'd7, 1'b0);
        send_op(ACT_PUT, CH_RETURN, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETPOS, 8'h00, 8'd5, 8'(NROWS - 1), 1'b0);
        send_op(ACT_PUT, CH_NEWLINE, 8'h00, 8'h00, 1'b0);
        send_op(ACT_PUT, CH_NEWLINE, 8'h00, 8'h00, 1'b0);
        // out-of-range coordinates are dropped one at a time
        send_op(ACT_SETPOS, 8'h00, 8'(NCOLS), 8'd3, 1'b0);
        send_op(ACT_SETPOS, 8'h00, 8'hFF, 8'hFF, 1'b1);
        send_op(ACT_SETPOS, 8'h00, 8'd10, 8'(NROWS), 1'b0);
        send_op(ACT_PUT, 8'h51, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETVIS, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_REDRAW, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETVIS, 8'h00, 8'h00, 8'h00, 1'b1);
        send_op(ACT_REDRAW, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_RESERVED_A, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_op(ACT_RESERVED_B, 8'h41, 8'h00, 8'h00, 1'b0);
        send_op(ACT_PUT, 8'h42, 8'h00, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_blink_timing();
        write_reg(REG_PERIOD, 16'd1);
        repeat (3) send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_REDRAW, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_REDRAW, 8'h00, 8'h00, 8'h00, 1'b0);
        wait_drained();
        write_reg(REG_PERIOD, 16'd3);
        repeat (4) send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        // hidden ticks keep counting, so the first shown tick toggles at once
        send_op(ACT_SETVIS, 8'h00, 8'h00, 8'h00, 1'b0);
        repeat (5) send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETVIS, 8'h00, 8'h00, 8'h00, 1'b1);
        send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_REDRAW, 8'h00, 8'h00, 8'h00, 1'b0);
        wait_drained();
    endtask

    // Long hidden run past the period, then show and tick.
    task automatic test_hidden_ticks();
        bit saved_idle;
        saved_idle = idle_on;
        idle_on = 1'b0;
        write_reg(REG_PERIOD, 16'd40);
        send_op(ACT_SETVIS, 8'h00, 8'h00, 8'h00, 1'b0);
        repeat (45) send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_SETVIS, 8'h00, 8'h00, 8'h00, 1'b1);
        repeat (2) send_op(ACT_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_op(ACT_REDRAW, 8'h00, 8'h00, 8'h00, 1'b0);
        wait_drained();
        idle_on = saved_idle;
    endtask

    task automatic test_random_traffic(input logic [7:0] fg, input logic [7:0] bg,
                                       input logic [15:0] period, input int count);
        write_reg(REG_FORE, fg);
        write_reg(REG_BACK, bg);
        write_reg(REG_PERIOD, period);
        repeat (count) send_word(random_item());
        wait_drained();
    endtask

    // Sink-side stall bursts
    initial begin : sink_ready
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_result want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            words_checked++;
            if (draw_words_due.size() == 0) begin
                report_mismatch("draw word with none due", o_m_axis_tuser, 0);
            end else begin
                want = draw_words_due.pop_front();
                check_field("command", o_m_axis_tuser, want.command);
                check_field("cell_col", o_m_axis_tdata[7:0], want.cell_col);
                check_field("cell_row", o_m_axis_tdata[14:8], want.cell_row);
                check_field("glyph_code", o_m_axis_tdata[22:15], want.glyph_code);
                check_field("fore_out", o_m_axis_tdata[30:23], want.fore_out);
                check_field("back_out", o_m_axis_tdata[38:31], want.back_out);
                check_field("last_of_run", o_m_axis_tlast, want.last_of_run);
            end
        end
    end

    initial begin : run_limit
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : main_sequence
        cur_col    = '0;
        cur_row    = '0;
        cur_shown  = 1'b1;
        blink_on   = 1'b1;
        tick_count = '0;
        fore_reg   = FORE_RST;
        back_reg   = BACK_RST;
        period_reg = PERIOD_RST;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_blink_timing();
        test_hidden_ticks();
        test_random_traffic(8'hFF, 8'h00, 16'd1, 140);
        test_random_traffic(8'h00, 8'hFF, 16'hFFFF, 140);
        test_random_traffic(8'($urandom), 8'($urandom), 16'($urandom_range(2, 20)), 140);
        idle_on = 1'b0;
        test_random_traffic(8'($urandom), 8'($urandom), 16'($urandom_range(1, 8)), 140);

        if (draw_words_due.size() != 0)
            report_mismatch("draw words never produced", draw_words_due.size(), 0);
        $display("Run covered %0d input words and %0d draw words: control characters,",
                 items_sent, words_checked);
        $display("wrap and scroll, blink timing with hidden tick counting, and random traffic.");
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
